@@ hw/rtl/scs_pkg.sv @@
// shared types and constants for the sound command sequencer
// no dependencies; imported by scs_divider, scs_core and the top level
package scs_pkg;

    localparam int PROG_DEPTH = 1024;
    localparam int PROG_AW    = $clog2(PROG_DEPTH);
    localparam int WORD_W     = 16;
    localparam int DELAY_W    = 24;
    localparam int VOL_W      = 7;
    localparam int SC_W       = 17;

    localparam logic [VOL_W-1:0]  VOL_MAX    = VOL_W'(100);
    localparam logic [WORD_W-1:0] LFSR_SEED  = 16'hACE1;

    localparam logic [2:0] OP_LOAD       = 3'd0;
    localparam logic [2:0] OP_START      = 3'd1;
    localparam logic [2:0] OP_TICK       = 3'd2;
    localparam logic [2:0] OP_STOP       = 3'd3;
    localparam logic [2:0] OP_STOP_QUIET = 3'd4;

    localparam logic [WORD_W-1:0] CMD_PLAY   = 16'd0;
    localparam logic [WORD_W-1:0] CMD_WAIT   = 16'd1;
    localparam logic [WORD_W-1:0] CMD_REPEAT = 16'd2;
    localparam logic [WORD_W-1:0] CMD_LOOP   = 16'd3;
    localparam logic [WORD_W-1:0] CMD_DELAY  = 16'd4;
    localparam logic [WORD_W-1:0] CMD_RDELAY = 16'd5;
    localparam logic [WORD_W-1:0] CMD_VOLUME = 16'd6;
    localparam logic [WORD_W-1:0] CMD_ATTEN  = 16'd7;
    localparam logic [WORD_W-1:0] CMD_HOLD   = 16'd8;
    localparam logic [WORD_W-1:0] CMD_END    = 16'd9;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_PLAY = 2'd1,
        ACT_STOP = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_ARG1,
        ST_ARG2,
        ST_DIV,
        ST_EMIT0,
        ST_EMIT1
    } state_t;

    typedef struct packed {
        action_t            action;
        logic [WORD_W-1:0]  sound_id;
        logic [VOL_W-1:0]   volume_pct;
        logic               running;
        logic               last;
    } res_t;

endpackage

@@ hw/rtl/scs_ram.sv @@
// generic single-clock ram, one write port and one read port, registered read
// no dependencies
module scs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/scs_divider.sv @@
// iterative restoring remainder unit, one quotient bit per cycle
// depends on scs_pkg
module scs_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [scs_pkg::WORD_W-1:0] dividend,
    input  logic [scs_pkg::WORD_W-1:0] divisor,
    output logic                       done,
    output logic [scs_pkg::WORD_W-1:0] remainder
);
    import scs_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] div_reg, div_next;
    logic [WORD_W:0]   trial;

    assign trial = {rem_reg, quo_reg[WORD_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = WORD_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
            end
            quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/scs_core.sv @@
// sequencer control: program memory access, command execution, result list
// depends on scs_pkg, scs_ram, scs_divider
module scs_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  op,
    input  logic [9:0]                  addr,
    input  logic [scs_pkg::WORD_W-1:0]  word,
    input  logic signed [scs_pkg::SC_W-1:0] stop_code,
    input  logic                        sound_busy,
    input  logic [scs_pkg::WORD_W-1:0]  elapsed,
    output logic                        push_valid,
    input  logic                        push_ready,
    output scs_pkg::res_t               push_res
);
    import scs_pkg::*;

    state_t             state_reg, state_next;
    logic [PROG_AW-1:0] pc_reg, pc_next;
    logic               active_reg, active_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [VOL_W-1:0]   volume_reg, volume_next;
    logic [SC_W-1:0]    sc_reg, sc_next;
    logic [WORD_W-1:0]  lfsr_reg, lfsr_next;

    logic               busy_reg, busy_next;
    logic [WORD_W-1:0]  cmd_reg, cmd_next;
    logic [WORD_W-1:0]  arg1_reg, arg1_next;
    logic [1:0]         nres_reg, nres_next;
    action_t            act0_reg, act0_next, act1_reg, act1_next;
    logic [WORD_W-1:0]  id0_reg, id0_next, id1_reg, id1_next;
    logic [VOL_W-1:0]   res_vol_reg, res_vol_next;

    logic               ram_we;
    logic [PROG_AW-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;
    logic               div_start, div_done;
    logic [WORD_W-1:0]  div_rem;

    logic [WORD_W-1:0]  lfsr_step;
    logic               sc_nonneg, sc_sound;
    logic               is_load, do_fetch;

    scs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PROG_DEPTH)
    ) u_prog (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    scs_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (lfsr_step),
        .divisor   (WORD_W'(ram_rdata - arg1_reg)),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign lfsr_step = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[WORD_W-1:1]};
    assign sc_nonneg = !sc_reg[SC_W-1];
    assign sc_sound  = sc_nonneg && (sc_reg[WORD_W-1:0] != '0);
    assign is_load   = (op == OP_LOAD);
    assign do_fetch  = (op == OP_TICK) && active_reg && (delay_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = do_fetch ? ST_CMD : ST_EMIT0;
                end
            end
            ST_CMD:   state_next = ST_ARG1;
            ST_ARG1:  state_next = ST_ARG2;
            ST_ARG2:
            begin
                if (cmd_reg == CMD_RDELAY && ram_rdata > arg1_reg)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_EMIT0;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT0;
                end
            end
            ST_EMIT0:
            begin
                if (push_ready)
                begin
                    state_next = (nres_reg == 2'd2) ? ST_EMIT1 : ST_IDLE;
                end
            end
            ST_EMIT1:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        ram_we     = (state_reg == ST_IDLE) && in_valid && is_load;
        ram_waddr  = PROG_AW'(addr);
        ram_raddr  = pc_reg;
        div_start  = 1'b0;
        push_valid = 1'b0;
        push_res.action     = act0_reg;
        push_res.sound_id   = id0_reg;
        push_res.volume_pct = res_vol_reg;
        push_res.running    = active_reg;
        push_res.last       = (nres_reg != 2'd2);
        unique case (state_reg)
            ST_CMD:   ram_raddr = pc_reg + PROG_AW'(1);
            ST_ARG1:  ram_raddr = pc_reg + PROG_AW'(2);
            ST_ARG2:
            begin
                div_start = (cmd_reg == CMD_RDELAY) && (ram_rdata > arg1_reg);
            end
            ST_EMIT0:
            begin
                push_valid = 1'b1;
                if (nres_reg == 2'd0)
                begin
                    push_res.action     = ACT_NONE;
                    push_res.sound_id   = '0;
                    push_res.volume_pct = volume_reg;
                end
            end
            ST_EMIT1:
            begin
                push_valid        = 1'b1;
                push_res.action   = act1_reg;
                push_res.sound_id = id1_reg;
                push_res.last     = 1'b1;
            end
            default:  ;
        endcase
    end

    // datapath
    always_comb
    begin
        pc_next      = pc_reg;
        active_next  = active_reg;
        delay_next   = delay_reg;
        volume_next  = volume_reg;
        sc_next      = sc_reg;
        lfsr_next    = lfsr_reg;
        busy_next    = busy_reg;
        cmd_next     = cmd_reg;
        arg1_next    = arg1_reg;
        nres_next    = nres_reg;
        act0_next    = act0_reg;
        act1_next    = act1_reg;
        id0_next     = id0_reg;
        id1_next     = id1_reg;
        res_vol_next = res_vol_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    nres_next    = 2'd0;
                    res_vol_next = volume_reg;
                    busy_next    = sound_busy;
                    act0_next    = ACT_STOP;
                    id0_next     = '0;
                    act1_next    = ACT_PLAY;
                    id1_next     = sc_reg[WORD_W-1:0];
                    if (op == OP_START || op == OP_STOP || op == OP_STOP_QUIET)
                    begin
                        if (active_reg && sc_nonneg)
                        begin
                            nres_next = (sc_sound && op != OP_STOP_QUIET) ? 2'd2 : 2'd1;
                        end
                        active_next = 1'b0;
                    end
                    if (op == OP_START)
                    begin
                        pc_next     = PROG_AW'(addr);
                        sc_next     = stop_code;
                        volume_next = VOL_MAX;
                        delay_next  = '0;
                        active_next = 1'b1;
                    end
                    if (op == OP_TICK && active_reg && delay_reg != '0)
                    begin
                        if (DELAY_W'(elapsed) >= delay_reg)
                        begin
                            delay_next = '0;
                        end
                        else
                        begin
                            delay_next = delay_reg - DELAY_W'(elapsed);
                        end
                    end
                end
            end
            ST_CMD:   cmd_next  = ram_rdata;
            ST_ARG1:  arg1_next = ram_rdata;
            ST_ARG2:
            begin
                act0_next = ACT_PLAY;
                id0_next  = arg1_reg;
                unique case (cmd_reg)
                    CMD_PLAY:
                    begin
                        nres_next = busy_reg ? 2'd0 : 2'd1;
                        pc_next   = pc_reg + PROG_AW'(2);
                    end
                    CMD_WAIT:
                    begin
                        if (!busy_reg)
                        begin
                            pc_next = pc_reg + PROG_AW'(1);
                        end
                    end
                    CMD_REPEAT: nres_next = busy_reg ? 2'd0 : 2'd1;
                    CMD_LOOP:
                    begin
                        nres_next  = 2'd1;
                        delay_next = {ram_rdata, 8'd0};
                    end
                    CMD_DELAY:
                    begin
                        delay_next = {arg1_reg, 8'd0};
                        pc_next    = pc_reg + PROG_AW'(2);
                    end
                    CMD_RDELAY:
                    begin
                        lfsr_next  = lfsr_step;
                        delay_next = {arg1_reg, 8'd0};
                        pc_next    = pc_reg + PROG_AW'(3);
                    end
                    CMD_VOLUME:
                    begin
                        volume_next = (arg1_reg > WORD_W'(VOL_MAX)) ? VOL_MAX
                                                                  : arg1_reg[VOL_W-1:0];
                        pc_next     = pc_reg + PROG_AW'(2);
                    end
                    CMD_ATTEN:  pc_next = pc_reg + PROG_AW'(2);
                    CMD_END:
                    begin
                        act0_next = ACT_STOP;
                        id0_next  = '0;
                        if (sc_nonneg)
                        begin
                            nres_next = sc_sound ? 2'd2 : 2'd1;
                        end
                        active_next = 1'b0;
                    end
                    default:    ;
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    delay_next = {WORD_W'(arg1_reg + div_rem), 8'd0};
                end
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pc_reg     <= '0;
            active_reg <= 1'b0;
            delay_reg  <= '0;
            volume_reg <= VOL_MAX;
            sc_reg     <= '1;
            lfsr_reg   <= LFSR_SEED;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            active_reg <= active_next;
            delay_reg  <= delay_next;
            volume_reg <= volume_next;
            sc_reg     <= sc_next;
            lfsr_reg   <= lfsr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        busy_reg    <= busy_next;
        cmd_reg     <= cmd_next;
        arg1_reg    <= arg1_next;
        nres_reg    <= nres_next;
        act0_reg    <= act0_next;
        act1_reg    <= act1_next;
        id0_reg     <= id0_next;
        id1_reg     <= id1_next;
        res_vol_reg <= res_vol_next;
    end

endmodule

@@ hw/rtl/sound_command_sequencer_unit.sv @@
// top level of the sound command sequencer: sequencer core and output register
// depends on scs_pkg, scs_core
//
// Input channel (in_valid/in_stall) carries load, start, tick and stop items;
// output channel (out_valid/out_stall) carries one or two results per item,
// the final one flagged by last. Each item is one transfer on the input side.
// Load, start and stop items, and ticks that run no command, go straight to
// the first emit state. A tick that runs a command reads up to three program
// words from the registered-read program ram, one per cycle, in the command
// and argument states before it emits; a random delay also waits in the
// divide state for the bit-serial remainder unit. A second result is sent
// from the second emit state. in_stall is high from the transfer until the
// item's last result enters the output register. A stalled result holds in
// the output register; once a new result is pending behind it, in_stall
// stays high until out_stall drops.
// Reset clears the sequence state: idle, volume 100, no stop code, random seed
// reloaded. Program memory is not cleared and must be loaded before use.
module sound_command_sequencer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      op,
    input  logic [9:0]                      addr,
    input  logic [scs_pkg::WORD_W-1:0]      word,
    input  logic signed [scs_pkg::SC_W-1:0] stop_code,
    input  logic                            sound_busy,
    input  logic [scs_pkg::WORD_W-1:0]      elapsed,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      action,
    output logic [scs_pkg::WORD_W-1:0]      sound_id,
    output logic [scs_pkg::VOL_W-1:0]       volume_pct,
    output logic                            running,
    output logic                            last
);
    import scs_pkg::*;

    logic out_valid_reg;
    res_t out_res_reg;
    logic push_valid, push_ready;
    res_t push_res;

    scs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .addr       (addr),
        .word       (word),
        .stop_code  (stop_code),
        .sound_busy (sound_busy),
        .elapsed    (elapsed),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_res   (push_res)
    );

    assign push_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            out_valid_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            out_res_reg <= push_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = out_res_reg.action;
    assign sound_id   = out_res_reg.sound_id;
    assign volume_pct = out_res_reg.volume_pct;
    assign running    = out_res_reg.running;
    assign last       = out_res_reg.last;

endmodule
